// File: rtl/pse_pkg.sv
// Package for the postfix stack evaluator: item types, command and status codes,
// back-end state encoding and sizing constants. No dependencies.
package pse_pkg;

    localparam int STACK_ENTRIES_DEF = 128;
    localparam int WORD_W            = 32;
    localparam int CMD_QUEUE_DEPTH   = 2;

    localparam logic [7:0] SYM_ZERO = 8'h30;
    localparam logic [7:0] SYM_NINE = 8'h39;
    localparam logic [7:0] SYM_ADD  = 8'h2b;
    localparam logic [7:0] SYM_SUB  = 8'h2d;
    localparam logic [7:0] SYM_MUL  = 8'h2a;
    localparam logic [7:0] SYM_DIV  = 8'h2f;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expr;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } t_out_item;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_OVERFLOW  = 3'd1,
        STAT_UNDERFLOW = 3'd2,
        STAT_DIVZERO   = 3'd3,
        STAT_INVALID   = 3'd4,
        STAT_DEPTH     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        KIND_DIGIT,
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV,
        KIND_BAD,
        KIND_END
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIVW
    } t_state;

endpackage

// File: rtl/pse_front.sv
// Front end: accepts input items, decodes them into commands and holds them
// in a short queue for the back end. Depends on pse_pkg.
module pse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  pse_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output pse_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);
    import pse_pkg::*;

    localparam int PW = $clog2(CMD_QUEUE_DEPTH);
    localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);

    t_cmd          r_queue [CMD_QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    t_cmd          dec_cmd;
    logic          push_ok;
    logic          pop_ok;

    always_comb begin
        dec_cmd.digit = 4'(i_item.symbol - SYM_ZERO);
        if (i_item.end_of_expr) begin
            dec_cmd.kind = KIND_END;
        end else begin
            unique case (i_item.symbol) inside
                [SYM_ZERO:SYM_NINE]: dec_cmd.kind = KIND_DIGIT;
                SYM_ADD:             dec_cmd.kind = KIND_ADD;
                SYM_SUB:             dec_cmd.kind = KIND_SUB;
                SYM_MUL:             dec_cmd.kind = KIND_MUL;
                SYM_DIV:             dec_cmd.kind = KIND_DIV;
                default:             dec_cmd.kind = KIND_BAD;
            endcase
        end
    end

    assign o_full      = (r_count == CW'(CMD_QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_queue[r_wr_ptr] <= dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/pse_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pse_pkg.
module pse_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pse_pkg::WORD_W-1:0] i_dividend,
    input  logic [pse_pkg::WORD_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pse_pkg::WORD_W-1:0] o_quotient
);
    import pse_pkg::*;

    localparam int CW = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;

    assign mag_a      = i_dividend[WORD_W-1] ? WORD_W'(0) - i_dividend : i_dividend;
    assign mag_b      = i_divisor[WORD_W-1]  ? WORD_W'(0) - i_divisor  : i_divisor;
    assign rem_shift  = {r_rem, r_quo[WORD_W-1]};
    assign diff       = rem_shift - {1'b0, r_dvs};
    assign o_done     = r_done;
    assign o_quotient = r_neg ? WORD_W'(0) - r_quo : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag_a;
            r_dvs <= mag_b;
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            r_rem <= diff[WORD_W] ? rem_shift[WORD_W-1:0] : diff[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], ~diff[WORD_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WORD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/pse_back.sv
// Back end: executes commands against the operand stack (top in a register,
// the rest in a memory), tracks the first error and holds the result item.
// Depends on pse_pkg and pse_div.
module pse_back #(
    parameter int STACK_ENTRIES = pse_pkg::STACK_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  pse_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_res_valid,
    output pse_pkg::t_out_item o_res,
    input  logic               i_res_pop
);
    import pse_pkg::*;

    localparam int AW = $clog2(STACK_ENTRIES);
    localparam int DW = $clog2(STACK_ENTRIES + 1);

    logic [WORD_W-1:0] r_mem [STACK_ENTRIES];
    logic [WORD_W-1:0] r_rd_data;

    t_state            r_state,     n_state;
    logic [DW-1:0]     r_depth,     n_depth;
    t_status           r_err,       n_err;
    logic [WORD_W-1:0] r_tos,       n_tos;
    t_kind             r_op,        n_op;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,       n_out;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_quo;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] dif;
    logic [WORD_W-1:0] prod;

    assign sum  = r_rd_data + r_tos;
    assign dif  = r_rd_data - r_tos;
    assign prod = r_rd_data * r_tos;

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rd_data),
        .i_divisor  (r_tos),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_err       = r_err;
        n_tos       = r_tos;
        n_op        = r_op;
        n_out_valid = r_out_valid && !i_res_pop;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(r_depth - 1'b1);
        mem_re      = 1'b0;
        mem_raddr   = AW'(r_depth - 2'd2);
        div_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == KIND_END) begin
                        if (!r_out_valid || i_res_pop) begin
                            o_cmd_pop   = 1'b1;
                            n_out_valid = 1'b1;
                            n_out.value = '0;
                            if (r_err != STAT_OK) begin
                                n_out.status = r_err;
                            end else if (r_depth == DW'(1)) begin
                                n_out.status = STAT_OK;
                                n_out.value  = r_tos;
                            end else begin
                                n_out.status = STAT_DEPTH;
                            end
                            n_depth = '0;
                            n_err   = STAT_OK;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        if (r_err == STAT_OK) begin
                            if (i_cmd.kind == KIND_DIGIT) begin
                                if (r_depth == DW'(STACK_ENTRIES)) begin
                                    n_err = STAT_OVERFLOW;
                                end else begin
                                    mem_we  = (r_depth != '0);
                                    n_tos   = WORD_W'(i_cmd.digit);
                                    n_depth = r_depth + 1'b1;
                                end
                            end else if (r_depth < DW'(2)) begin
                                n_err = STAT_UNDERFLOW;
                            end else if (i_cmd.kind == KIND_BAD) begin
                                n_err = STAT_INVALID;
                            end else begin
                                mem_re  = 1'b1;
                                n_op    = i_cmd.kind;
                                n_state = ST_READ;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (r_op)
                    KIND_ADD: begin
                        n_tos   = sum;
                        n_depth = r_depth - 1'b1;
                    end
                    KIND_SUB: begin
                        n_tos   = dif;
                        n_depth = r_depth - 1'b1;
                    end
                    KIND_MUL: begin
                        n_tos   = prod;
                        n_depth = r_depth - 1'b1;
                    end
                    default: begin
                        if (r_tos == '0) begin
                            n_err = STAT_DIVZERO;
                        end else begin
                            div_start = 1'b1;
                            n_state   = ST_DIVW;
                        end
                    end
                endcase
            end
            ST_DIVW: begin
                if (div_done) begin
                    n_tos   = div_quo;
                    n_depth = r_depth - 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_tos;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        r_op  <= n_op;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= '0;
            r_err       <= STAT_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// File: rtl/postfix_stack_evaluator_core.sv
// Top level of the postfix stack evaluator: front-end decoder and command queue
// feeding the stack execution back end. Depends on pse_pkg, pse_front, pse_back.
//
//   channel   direction   handshake           payload
//   input     in          push / full         i_item   (symbol, end_of_expr)
//   result    out         pop / empty         o_result (value, status)
//
// Back-end path per item: digit, ignored item, decode-time error and end item in IDLE;
// + - * via operand read (READ) and execute (EXEC); / then also the 32-step divider (DIVW).
// The input side takes items into a two-entry command queue while the back end works.
// Reset is synchronous, active low; stack contents are not cleared (never read unwritten).
// An end item waits in the queue while an earlier result is still held, stalling input.
module postfix_stack_evaluator_core #(
    parameter int STACK_ENTRIES = pse_pkg::STACK_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pse_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output pse_pkg::t_out_item o_result
);
    import pse_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic res_valid;

    pse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    pse_back #(
        .STACK_ENTRIES (STACK_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (o_result),
        .i_res_pop   (pop)
    );

    assign empty = !res_valid;

endmodule

// File: tb/postfix_stack_evaluator_core_test.sv
`timescale 1ns / 100ps
// Testbench for postfix_stack_evaluator_core: directed and random postfix expressions,
// checked against a scoreboard that evaluates them itself. Depends on pse_pkg and the RTL.
import pse_pkg::*;

class expr_scoreboard;
    logic [31:0] stk [STACK_ENTRIES_DEF];
    int unsigned depth = 0;
    t_status     err = STAT_OK;
    t_out_item   expected_q[$];
    int          errors = 0;

    function void note_input(t_in_item it);
        logic [31:0] lhs, rhs, res, ml, mr, q;
        t_out_item r;
        if (it.end_of_expr) begin
            r.status = err;
            r.value = '0;
            if (err == STAT_OK) begin
                if (depth == 1) r.value = stk[0];
                else r.status = STAT_DEPTH;
            end
            expected_q.push_back(r);
            depth = 0;
            err = STAT_OK;
            return;
        end
        if (err != STAT_OK) return;
        if (it.symbol >= SYM_ZERO && it.symbol <= SYM_NINE) begin
            if (depth >= STACK_ENTRIES_DEF) begin
                err = STAT_OVERFLOW;
            end else begin
                stk[depth] = 32'(it.symbol - SYM_ZERO);
                depth++;
            end
            return;
        end
        if (depth < 2) begin
            err = STAT_UNDERFLOW;
            return;
        end
        rhs = stk[depth-1];
        lhs = stk[depth-2];
        case (it.symbol)
            SYM_ADD: res = lhs + rhs;
            SYM_SUB: res = lhs - rhs;
            SYM_MUL: res = lhs * rhs;
            SYM_DIV: begin
                if (rhs == 0) begin
                    err = STAT_DIVZERO;
                    return;
                end
                ml = lhs[31] ? -lhs : lhs;
                mr = rhs[31] ? -rhs : rhs;
                q = ml / mr;
                res = (lhs[31] ^ rhs[31]) ? -q : q;
            end
            default: begin
                err = STAT_INVALID;
                return;
            end
        endcase
        stk[depth-2] = res;
        depth--;
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, value %0d status %0d", $time, got.value,
                     got.status);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got.value !== want.value) begin
            $display("%0t: value expected %0d got %0d", $time, want.value, got.value);
            errors++;
        end
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
        end
    endfunction
endclass

module postfix_stack_evaluator_core_test;
    localparam int STACK_ENTRIES = STACK_ENTRIES_DEF;
    localparam int ITEM_TARGET   = 1050;
    localparam int QUIET_FROM    = 900;
    localparam int HOLD_FROM     = 350;
    localparam int HOLD_CYCLES   = 3000;
    localparam int DRAIN_CYCLES  = 100;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;

    expr_scoreboard sb = new();
    int  sent_count = 0;
    bit  quiet = 0;
    bit  gap_mode = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    logic [7:0] op_syms [4] = '{SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV};

    postfix_stack_evaluator_core #(.STACK_ENTRIES(STACK_ENTRIES)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_item(input t_in_item it);
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_input(it);
        sent_count++;
        if (!quiet && gap_mode && hold_left == 0 && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic send_sym(input logic [7:0] sym);
        t_in_item it;
        it.symbol = sym;
        it.end_of_expr = 1'b0;
        send_item(it);
    endtask

    task automatic send_end();
        t_in_item it;
        it.symbol = 8'($urandom_range(0, 255));
        it.end_of_expr = 1'b1;
        send_item(it);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_sym(s[k]);
        send_end();
    endtask

    task automatic send_digits(input int n);
        for (int k = 0; k < n; k++) send_sym(SYM_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // well-formed expression; junk_pct mixes in random symbols
    task automatic send_expr(input int n_ops, input bit all_first, input int junk_pct);
        int digits_left, ops_left, d;
        digits_left = n_ops + 1;
        ops_left = n_ops;
        d = 0;
        while (digits_left + ops_left > 0) begin
            if ($urandom_range(0, 99) < junk_pct) send_sym(8'($urandom_range(0, 255)));
            if (digits_left > 0 && (d < 2 || all_first || $urandom_range(0, 1))) begin
                send_sym(SYM_ZERO + 8'($urandom_range(0, 9)));
                digits_left--;
                d++;
            end else begin
                send_sym(op_syms[$urandom_range(0, 3)]);
                ops_left--;
                d--;
            end
        end
        send_end();
    endtask

    task automatic send_broken();
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 1)) send_sym(SYM_ZERO + 8'($urandom_range(0, 9)));
            else send_sym(op_syms[$urandom_range(0, 3)]);
        end
        send_end();
    endtask

    initial begin
        int kind;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("9");
        send_text("");
        send_text("12");
        send_text("09-");
        send_text("73/");
        send_text("07-2/");
        send_text("70/");
        send_text("+");
        send_text("5x");
        send_text("55x");
        send_text("5+34+");
        send_text("93*");
        send_sym(SYM_ZERO + 8'd5);
        send_sym(SYM_ZERO + 8'd5);
        send_sym(8'hff);
        send_end();
        send_sym(8'h00);
        send_end();
        // most negative number divided by -1
        send_sym(SYM_ZERO + 8'd8);
        repeat (9) begin
            send_sym(SYM_ZERO + 8'd8);
            send_sym(SYM_MUL);
        end
        send_text("2*01-/");
        send_digits(STACK_ENTRIES);
        send_end();
        send_digits(STACK_ENTRIES + 1);
        send_end();
        send_expr(STACK_ENTRIES - 1, 1'b1, 0);

        while (sent_count < ITEM_TARGET) begin
            if (sent_count >= HOLD_FROM) hold_req = 1;
            if (sent_count >= QUIET_FROM) quiet = 1;
            gap_mode = $urandom_range(0, 2) != 0;
            kind = $urandom_range(0, 79);
            if (kind < 56) send_expr($urandom_range(0, 8), 1'b0, 0);
            else if (kind < 64) send_expr($urandom_range(0, 8), 1'b0, 15);
            else if (kind < 74) send_broken();
            else if (kind < 78) send_expr($urandom_range(9, 30), 1'b0, 0);
            else if (kind < 79) send_expr($urandom_range(60, STACK_ENTRIES - 1), 1'b1, 0);
            else begin
                send_digits($urandom_range(STACK_ENTRIES - 2, STACK_ENTRIES + 3));
                send_end();
            end
        end
        push <= 1'b0;

        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("postfix_stack_evaluator_core verification clean");
        end else begin
            $display("postfix_stack_evaluator_core verification failed");
        end
        $finish;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(o_result);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("postfix_stack_evaluator_core verification failed");
        $finish;
    end
endmodule
